// File: rtl/sca_pkg.sv
`timescale 1ns / 1ps
// Shared constants, codes and types of the size-class block allocator.
// Depends on nothing; the other files of the block, all but sca_ram, refer to it by scoped names.
package sca_pkg;

   // Number of size classes and blocks per class.
   localparam int CLASSES = 8;
   localparam int BLOCKS  = 64;

   // Derived widths.
   localparam int IDX_W  = $clog2(BLOCKS);
   localparam int CNT_W  = $clog2(BLOCKS + 1);
   localparam int CLS_W  = 4;
   localparam int CIDX_W = (CLASSES > 1) ? $clog2(CLASSES) : 1;
   localparam int SLOTS  = CLASSES * BLOCKS;
   localparam int ADDR_W = $clog2(SLOTS);

   // Command queue between the front and the back end.
   localparam int QDEPTH = 2;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   typedef enum logic {
      CMD_ALLOC = 1'b0,
      CMD_FREE  = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_TOO_LARGE  = 2'd1,
      ST_EXHAUSTED  = 2'd2,
      ST_NOT_IN_USE = 2'd3
   } status_type;

   // One classified request as it travels through the queue.
   typedef struct packed {
      cmd_type          cmd;
      logic             too_large;
      logic [CLS_W-1:0] cls;
      logic [5:0]       fidx;
   } qitem_type;

   // Flat memory address of one block of one class.
   function automatic logic [ADDR_W-1:0] slot_addr(logic [CLS_W-1:0] cls,
                                                   logic [IDX_W-1:0] idx);
      return ADDR_W'(32'(cls) * 32'(BLOCKS) + 32'(idx));
   endfunction

endpackage

// File: rtl/sca_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module sca_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rd_data_ff <= mem_ff[raddr];
   end

   assign rdata = rd_data_ff;

endmodule

// File: rtl/sca_front.sv
`timescale 1ns / 1ps
// Front end: turns a raw request into a classified queue entry.
// Depends on sca_pkg.
module sca_front (
   input  logic                  req_cmd,
   input  logic [15:0]           req_req_size,
   input  logic [5:0]            req_free_index,
   output sca_pkg::qitem_type    item
);

   logic [15:0]               size_m1;
   logic [3:0]                msb;
   logic [sca_pkg::CLS_W-1:0] cls;

   // The class is ceil(log2(size)) - 2, which for sizes above four equals
   // the position of the leading one of (size - 1), minus one.
   always_comb begin
      size_m1 = req_req_size - 16'd1;
      msb     = '0;
      for (int i = 0; i < 16; i++) begin
         if (size_m1[i]) begin
            msb = 4'(i);
         end
      end
      if (req_req_size <= 16'd4) begin
         cls = '0;
      end else begin
         cls = sca_pkg::CLS_W'(msb - 4'd1);
      end
   end

   always_comb begin
      item.cmd       = sca_pkg::cmd_type'(req_cmd);
      item.cls       = cls;
      item.too_large = (32'(cls) >= sca_pkg::CLASSES);
      item.fidx      = req_free_index;
   end

endmodule

// File: rtl/sca_fifo.sv
`timescale 1ns / 1ps
// Short queue of classified requests between the front and the back end.
// Depends on sca_pkg.
module sca_fifo (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  sca_pkg::qitem_type push_item,
   input  logic               pop,
   output sca_pkg::qitem_type head_item,
   output logic               empty,
   output logic               full
);

   sca_pkg::qitem_type         slot_ff [sca_pkg::QDEPTH];
   logic [sca_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [sca_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [sca_pkg::QCNT_W-1:0] count_ff, count_in;
   logic                       do_push, do_pop;

   assign empty   = (count_ff == '0);
   assign full    = (count_ff == sca_pkg::QCNT_W'(sca_pkg::QDEPTH));
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head_item = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == sca_pkg::QPTR_W'(sca_pkg::QDEPTH - 1)) ?
                     '0 : wr_ptr_ff + sca_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == sca_pkg::QPTR_W'(sca_pkg::QDEPTH - 1)) ?
                     '0 : rd_ptr_ff + sca_pkg::QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + sca_pkg::QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - sca_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// File: rtl/sca_back.sv
`timescale 1ns / 1ps
// Back end: executes queued allocate and free commands against the per-class
// free stacks and in-use bits. Depends on sca_pkg and sca_ram.
module sca_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_empty,
   input  sca_pkg::qitem_type    q_head,
   output logic                  q_pop,
   output logic                  rsp_strobe,
   output logic [1:0]            rsp_status,
   output logic [2:0]            rsp_size_class,
   output logic [5:0]            rsp_block_index,
   output logic [15:0]           rsp_byte_offset
);

   typedef enum logic [1:0] {
      B_IDLE = 2'b01,
      B_EXEC = 2'b10
   } bstate_type;

   bstate_type state_ff, state_in;
   sca_pkg::qitem_type item_ff;

   logic [sca_pkg::CNT_W-1:0] depth_ff [sca_pkg::CLASSES];
   logic [sca_pkg::CNT_W-1:0] fresh_ff [sca_pkg::CLASSES];

   logic                 rsp_strobe_ff;
   sca_pkg::status_type  rsp_status_ff;
   logic [2:0]           rsp_class_ff;
   logic [5:0]           rsp_index_ff;
   logic [15:0]          rsp_offset_ff;

   // Issue side, driven by the head of the queue.
   logic [sca_pkg::CIDX_W-1:0] hd_cls;
   logic [sca_pkg::CNT_W-1:0]  hd_top;
   logic [15:0]                hd_fidx_w;

   // Execute side.
   logic [sca_pkg::CIDX_W-1:0] ex_cls;
   logic [sca_pkg::CNT_W-1:0]  depth_c, fresh_c, depth_in, fresh_in;
   logic [15:0]                fidx_w;
   logic [sca_pkg::IDX_W-1:0]  fidx_n, res_idx;
   logic [15:0]                res_idx_w;
   logic [31:0]                off_w;
   sca_pkg::status_type        res_status;
   logic [2:0]                 res_class;
   logic [5:0]                 res_index;
   logic [15:0]                res_offset;

   // Memory ports.
   logic                        stack_we;
   logic [sca_pkg::ADDR_W-1:0]  stack_waddr, stack_raddr;
   logic [sca_pkg::IDX_W-1:0]   stack_wdata, stack_rdata;
   logic                        inuse_we;
   logic [sca_pkg::ADDR_W-1:0]  inuse_waddr, inuse_raddr;
   logic                        inuse_wdata, inuse_rdata;

   sca_ram #(.WIDTH(sca_pkg::IDX_W), .DEPTH(sca_pkg::SLOTS)) u_stack_ram (
      .clock (clock),
      .we    (stack_we),
      .waddr (stack_waddr),
      .wdata (stack_wdata),
      .raddr (stack_raddr),
      .rdata (stack_rdata)
   );

   sca_ram #(.WIDTH(1), .DEPTH(sca_pkg::SLOTS)) u_inuse_ram (
      .clock (clock),
      .we    (inuse_we),
      .waddr (inuse_waddr),
      .wdata (inuse_wdata),
      .raddr (inuse_raddr),
      .rdata (inuse_rdata)
   );

   // Reads are issued while the command leaves the queue: the top of the
   // class's free stack and the in-use bit of the block named for a free.
   always_comb begin
      q_pop       = (state_ff == B_IDLE) && !q_empty;
      hd_cls      = q_head.cls[sca_pkg::CIDX_W-1:0];
      hd_top      = depth_ff[hd_cls] - sca_pkg::CNT_W'(1);
      hd_fidx_w   = 16'(q_head.fidx);
      stack_raddr = sca_pkg::slot_addr(q_head.cls, hd_top[sca_pkg::IDX_W-1:0]);
      inuse_raddr = sca_pkg::slot_addr(q_head.cls, hd_fidx_w[sca_pkg::IDX_W-1:0]);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         B_IDLE: begin
            if (q_pop) begin
               state_in = B_EXEC;
            end
         end
         B_EXEC: begin
            state_in = B_IDLE;
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   // Decision and write-back. An in-use bit is only trusted below the class's
   // fresh index, since every entry there was written when it was handed out.
   always_comb begin
      ex_cls      = item_ff.cls[sca_pkg::CIDX_W-1:0];
      depth_c     = depth_ff[ex_cls];
      fresh_c     = fresh_ff[ex_cls];
      depth_in    = depth_c;
      fresh_in    = fresh_c;
      fidx_w      = 16'(item_ff.fidx);
      fidx_n      = fidx_w[sca_pkg::IDX_W-1:0];
      res_idx     = '0;
      stack_we    = 1'b0;
      stack_waddr = sca_pkg::slot_addr(item_ff.cls, depth_c[sca_pkg::IDX_W-1:0]);
      stack_wdata = fidx_n;
      inuse_we    = 1'b0;
      inuse_wdata = 1'b0;
      res_status  = sca_pkg::ST_OK;
      res_class   = item_ff.cls[2:0];
      if (item_ff.too_large) begin
         res_status = sca_pkg::ST_TOO_LARGE;
         res_class  = '0;
      end else if (item_ff.cmd == sca_pkg::CMD_ALLOC) begin
         if (depth_c != '0) begin
            res_idx  = (32'(stack_rdata) >= sca_pkg::BLOCKS) ? '0 : stack_rdata;
            depth_in = depth_c - sca_pkg::CNT_W'(1);
         end else if (32'(fresh_c) < sca_pkg::BLOCKS) begin
            res_idx  = fresh_c[sca_pkg::IDX_W-1:0];
            fresh_in = fresh_c + sca_pkg::CNT_W'(1);
         end else begin
            res_status = sca_pkg::ST_EXHAUSTED;
         end
         if (res_status == sca_pkg::ST_OK) begin
            inuse_we    = 1'b1;
            inuse_wdata = 1'b1;
         end
      end else begin
         res_idx = fidx_n;
         if ((fidx_w < 16'(sca_pkg::BLOCKS)) && (fidx_w < 16'(fresh_c)) &&
             inuse_rdata && (32'(depth_c) < sca_pkg::BLOCKS)) begin
            inuse_we = 1'b1;
            stack_we = 1'b1;
            depth_in = depth_c + sca_pkg::CNT_W'(1);
         end else begin
            res_status = sca_pkg::ST_NOT_IN_USE;
         end
      end
      inuse_waddr = sca_pkg::slot_addr(item_ff.cls, res_idx);
      if (state_ff != B_EXEC) begin
         stack_we = 1'b0;
         inuse_we = 1'b0;
      end

      // Payload offset: idx * (8 + (4 << k)) + 8 as two shifts and two adds.
      res_idx_w = 16'(res_idx);
      off_w     = (32'(res_idx) << (32'(item_ff.cls) + 32'd2)) +
                  (32'(res_idx) << 3) + 32'd8;
      res_index  = '0;
      res_offset = '0;
      if (res_status == sca_pkg::ST_OK) begin
         res_index  = res_idx_w[5:0];
         res_offset = off_w[15:0];
      end else if (res_status == sca_pkg::ST_NOT_IN_USE) begin
         res_index = item_ff.fidx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= B_IDLE;
         rsp_strobe_ff <= 1'b0;
         for (int c = 0; c < sca_pkg::CLASSES; c++) begin
            depth_ff[c] <= '0;
            fresh_ff[c] <= '0;
         end
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= (state_ff == B_EXEC);
         if ((state_ff == B_EXEC) && !item_ff.too_large) begin
            depth_ff[ex_cls] <= depth_in;
            fresh_ff[ex_cls] <= fresh_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         item_ff <= q_head;
      end
      if (state_ff == B_EXEC) begin
         rsp_status_ff <= res_status;
         rsp_class_ff  <= res_class;
         rsp_index_ff  <= res_index;
         rsp_offset_ff <= res_offset;
      end
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_size_class  = rsp_class_ff;
   assign rsp_block_index = rsp_index_ff;
   assign rsp_byte_offset = rsp_offset_ff;

`ifndef NO_ASSERTIONS
   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("back end state is not one-hot");

   a_exec_one_cycle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_EXEC) |=> (state_ff == B_IDLE))
      else $error("execute state held for more than one cycle");

   a_exec_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_EXEC) |=> rsp_strobe_ff)
      else $error("executed command produced no response");

   a_rsp_from_exec: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> $past(state_ff == B_EXEC))
      else $error("response without an executed command");

   a_freed_le_issued: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == B_EXEC) && !item_ff.too_large) |-> (depth_c <= fresh_c))
      else $error("free stack deeper than the number of blocks issued");
`endif

endmodule

// File: rtl/size_class_block_allocator_core.sv
`timescale 1ns / 1ps
// Top level of the size-class block allocator: front end, command queue and
// back end. Depends on sca_pkg, sca_front, sca_fifo and sca_back.
//
// The allocator hands out fixed blocks from power-of-two size classes and
// takes them back. A request is transferred at a rising edge where start is
// high and busy is low; the front end works out the size class at once and
// places the command in a two-entry queue. The back end takes one command
// at a time: in its idle state, as the command leaves the queue, it reads the
// top of the class's free stack and the block's in-use bit from memory; in
// its execute state it decides, writes both memories back and updates the
// per-class counters. It takes no new command before that write-back of the
// class state is done. With an empty queue the command passes from the queue
// slot through the command register, and its result appears on the registered
// rsp_ ports, marked by rsp_strobe for one cycle; the receiver must take it
// then, since results cannot be held off. busy rises only while the queue is
// full. Results come back in request order, exactly one per request. The
// in-use bits need no clearing pass after reset: a bit is only consulted for
// blocks below the class's never-issued index, all of which were written when
// handed out, so the block is ready as soon as reset is released.
module size_class_block_allocator_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_cmd,
   input  logic [15:0] req_req_size,
   input  logic [5:0]  req_free_index,
   output logic        rsp_strobe,
   output logic [1:0]  rsp_status,
   output logic [2:0]  rsp_size_class,
   output logic [5:0]  rsp_block_index,
   output logic [15:0] rsp_byte_offset
);

   sca_pkg::qitem_type front_item;
   sca_pkg::qitem_type head_item;
   logic               q_full;
   logic               q_empty;
   logic               q_pop;

   // Classify the incoming request; no state lives in the front end.
   sca_front u_front (
      .req_cmd        (req_cmd),
      .req_req_size   (req_req_size),
      .req_free_index (req_free_index),
      .item           (front_item)
   );

   // The queue lets the requester keep transferring while the back end works.
   sca_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (start && !q_full),
      .push_item (front_item),
      .pop       (q_pop),
      .head_item (head_item),
      .empty     (q_empty),
      .full      (q_full)
   );

   sca_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_empty         (q_empty),
      .q_head          (head_item),
      .q_pop           (q_pop),
      .rsp_strobe      (rsp_strobe),
      .rsp_status      (rsp_status),
      .rsp_size_class  (rsp_size_class),
      .rsp_block_index (rsp_block_index),
      .rsp_byte_offset (rsp_byte_offset)
   );

   assign busy = q_full;

endmodule

// File: sim/sca_allocation_checker.sv
`timescale 1ns / 1ps
// Checker for the size-class block allocator: watches request and result transfers,
// keeps its own copy of the free stacks, counters and in-use bits, and compares.
// Depends on sca_pkg for the command and status codes and the class and block counts.
module sca_allocation_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic        req_cmd,
   input  logic [15:0] req_req_size,
   input  logic [5:0]  req_free_index,
   input  logic        rsp_strobe,
   input  logic [1:0]  rsp_status,
   input  logic [2:0]  rsp_size_class,
   input  logic [5:0]  rsp_block_index,
   input  logic [15:0] rsp_byte_offset,
   output int unsigned mismatch_count,
   output int unsigned outstanding
);

   typedef struct packed {
      sca_pkg::status_type status;
      logic [2:0]          cls;
      logic [5:0]          idx;
      logic [15:0]         off;
   } block_answer_type;

   logic [5:0] freed_idx  [sca_pkg::CLASSES][sca_pkg::BLOCKS];
   logic [6:0] free_depth [sca_pkg::CLASSES];
   logic [6:0] fresh_next [sca_pkg::CLASSES];
   bit         held_now   [sca_pkg::CLASSES][sca_pkg::BLOCKS];

   block_answer_type answer_q[$];
   int unsigned      misses;

   // Class 0 covers sizes up to 4; above that the class is ceil(log2(size)) - 2.
   function automatic int unsigned size_class_of(logic [15:0] sz);
      int unsigned n;
      n = 0;
      if (sz <= 16'd4)
         return 0;
      while ((32'd1 << n) < 32'(sz))
         n++;
      return n - 2;
   endfunction

   function automatic logic [15:0] payload_offset(int unsigned k, logic [5:0] idx);
      logic [31:0] full;
      full = 32'(idx) * (32'd8 + (32'd4 << k)) + 32'd8;
      return full[15:0];
   endfunction

   function automatic block_answer_type apply_request(logic cmd, logic [15:0] sz,
                                                      logic [5:0] fidx);
      block_answer_type res;
      int unsigned      k;
      logic [5:0]       idx;
      res = '0;
      res.status = sca_pkg::ST_OK;
      k = size_class_of(sz);
      if (k >= sca_pkg::CLASSES) begin
         res.status = sca_pkg::ST_TOO_LARGE;
         return res;
      end
      res.cls = k[2:0];
      if (cmd == sca_pkg::CMD_ALLOC) begin
         if (free_depth[k] > 0) begin
            free_depth[k] = free_depth[k] - 7'd1;
            idx = freed_idx[k][free_depth[k]];
         end else if (fresh_next[k] < sca_pkg::BLOCKS) begin
            idx = fresh_next[k][5:0];
            fresh_next[k] = fresh_next[k] + 7'd1;
         end else begin
            res.status = sca_pkg::ST_EXHAUSTED;
            return res;
         end
         held_now[k][idx] = 1'b1;
         res.idx = idx;
         res.off = payload_offset(k, idx);
         return res;
      end
      res.idx = fidx;
      if (!held_now[k][fidx] || free_depth[k] >= sca_pkg::BLOCKS) begin
         res.status = sca_pkg::ST_NOT_IN_USE;
         return res;
      end
      held_now[k][fidx] = 1'b0;
      freed_idx[k][free_depth[k]] = fidx;
      free_depth[k] = free_depth[k] + 7'd1;
      res.off = payload_offset(k, fidx);
      return res;
   endfunction

   function automatic void report_miss(string what, block_answer_type want,
                                       block_answer_type got);
      misses++;
      if (misses <= 10)
         $display({"%s: expected status %0d class %0d index %0d offset %0d, ",
                   "got status %0d class %0d index %0d offset %0d"},
                  what, want.status, want.cls, want.idx, want.off,
                  got.status, got.cls, got.idx, got.off);
   endfunction

   always @(posedge clock) begin : watch
      block_answer_type got;
      block_answer_type want;
      if (reset) begin
         for (int c = 0; c < sca_pkg::CLASSES; c++) begin
            free_depth[c] = '0;
            fresh_next[c] = '0;
            for (int b = 0; b < sca_pkg::BLOCKS; b++)
               held_now[c][b] = 1'b0;
         end
         answer_q.delete();
         misses = 0;
      end else begin
         if (rsp_strobe) begin
            got.status = sca_pkg::status_type'(rsp_status);
            got.cls    = rsp_size_class;
            got.idx    = rsp_block_index;
            got.off    = rsp_byte_offset;
            if (answer_q.size() == 0) begin
               report_miss("unexpected result", '0, got);
            end else begin
               want = answer_q.pop_front();
               if (got.status != want.status || got.cls != want.cls
                   || got.idx != want.idx || got.off != want.off)
                  report_miss("result mismatch", want, got);
            end
         end
         if (start && !busy)
            answer_q.insert(answer_q.size(),
                            apply_request(req_cmd, req_req_size, req_free_index));
      end
      mismatch_count <= misses;
      outstanding    <= answer_q.size();
   end

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// Top of the allocator testbench: clock, reset, request stimulus and the verdict.
// Depends on sca_pkg, size_class_block_allocator_core and sca_allocation_checker.
module tb_top;

   // Generous bound: about 1800 requests, each at worst with a long gap
   // plus its service time, taken several times over.
   localparam int unsigned CYCLE_LIMIT = 400000;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic        req_cmd;
   logic [15:0] req_req_size;
   logic [5:0]  req_free_index;
   logic        rsp_strobe;
   logic [1:0]  rsp_status;
   logic [2:0]  rsp_size_class;
   logic [5:0]  rsp_block_index;
   logic [15:0] rsp_byte_offset;

   int unsigned mismatch_count;
   int unsigned outstanding;
   int unsigned cycle_count;

   // Blocks the stimulus believes are handed out, learned from the results of
   // allocations. Frees are mostly drawn from here so that they succeed.
   bit   held [sca_pkg::CLASSES][sca_pkg::BLOCKS];
   logic issued_cmds[$];

   size_class_block_allocator_core i_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_cmd         (req_cmd),
      .req_req_size    (req_req_size),
      .req_free_index  (req_free_index),
      .rsp_strobe      (rsp_strobe),
      .rsp_status      (rsp_status),
      .rsp_size_class  (rsp_size_class),
      .rsp_block_index (rsp_block_index),
      .rsp_byte_offset (rsp_byte_offset)
   );

   sca_allocation_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_cmd         (req_cmd),
      .req_req_size    (req_req_size),
      .req_free_index  (req_free_index),
      .rsp_strobe      (rsp_strobe),
      .rsp_status      (rsp_status),
      .rsp_size_class  (rsp_size_class),
      .rsp_block_index (rsp_block_index),
      .rsp_byte_offset (rsp_byte_offset),
      .mismatch_count  (mismatch_count),
      .outstanding     (outstanding)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // The run is cut off if it hangs, for instance when a result never arrives.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Results come back in request order, so the command of each result is the
   // oldest one transferred and not yet answered. A successful allocation
   // marks its block as held.
   always @(posedge clock) begin
      if (reset) begin
         issued_cmds.delete();
      end else begin
         if (start && !busy)
            issued_cmds.insert(issued_cmds.size(), req_cmd);
         if (rsp_strobe && issued_cmds.size() != 0) begin
            if (issued_cmds.pop_front() == sca_pkg::CMD_ALLOC &&
                rsp_status == sca_pkg::ST_OK)
               held[rsp_size_class][rsp_block_index] = 1'b1;
         end
      end
   end

   // Called at a falling edge. start stays high after the transfer, so a
   // following request with no gap goes out on the very next edge unless busy is high.
   task automatic send_request(sca_pkg::cmd_type cmd, logic [15:0] sz, logic [5:0] fidx);
      start          = 1'b1;
      req_cmd        = cmd;
      req_req_size   = sz;
      req_free_index = fidx;
      @(posedge clock);
      while (busy)
         @(posedge clock);
      @(negedge clock);
   endtask

   task automatic idle_for(int unsigned n);
      if (n > 0) begin
         start = 1'b0;
         repeat (n) @(negedge clock);
      end
   endtask

   // Mostly no gap, often a short one, now and then a long one.
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(5, 40);
   endfunction

   // A random size inside class k: class 0 is 0..4, class k above that is
   // (2 << k) + 1 up to 4 << k.
   function automatic logic [15:0] size_for_class(int unsigned k);
      if (k == 0)
         return 16'($urandom_range(0, 4));
      return 16'($urandom_range((1 << (k + 1)) + 1, 1 << (k + 2)));
   endfunction

   // Returns a block of class k believed to be held, or -1 when there is none.
   function automatic int pick_held(int unsigned k);
      int unsigned first;
      int unsigned j;
      first = $urandom_range(0, sca_pkg::BLOCKS - 1);
      for (int i = 0; i < sca_pkg::BLOCKS; i++) begin
         j = (first + i) % sca_pkg::BLOCKS;
         if (held[k][j])
            return j;
      end
      return -1;
   endfunction

   // One stretch of random traffic. Most requests go to one busy class so that
   // its stack fills and empties and, with a high allocation share, the class
   // runs out of blocks. Frees are mostly of held blocks; the rest are random
   // indexes, which gives double frees and frees of blocks never issued.
   task automatic random_round(int unsigned hot, int unsigned alloc_share,
                               bit unsigned no_gaps, int unsigned count);
      int unsigned      r;
      int unsigned      k;
      int               pick;
      sca_pkg::cmd_type cmd;
      logic [15:0]      sz;
      logic [5:0]       fidx;
      for (int n = 0; n < count; n++) begin
         r    = $urandom_range(0, 99);
         cmd  = ($urandom_range(0, 99) < alloc_share) ? sca_pkg::CMD_ALLOC : sca_pkg::CMD_FREE;
         fidx = 6'($urandom_range(0, sca_pkg::BLOCKS - 1));
         if (r < 5) begin
            sz = 16'($urandom_range(513, 65535));
         end else begin
            k  = (r < 80) ? hot : $urandom_range(0, sca_pkg::CLASSES - 1);
            sz = size_for_class(k);
            if (cmd == sca_pkg::CMD_FREE && $urandom_range(0, 99) < 85) begin
               pick = pick_held(k);
               if (pick >= 0) begin
                  fidx = 6'(pick);
                  held[k][pick] = 1'b0;
               end
            end
         end
         send_request(cmd, sz, fidx);
         if (!no_gaps)
            idle_for(pick_gap());
      end
   endtask

   initial begin
      reset          = 1'b1;
      start          = 1'b0;
      req_cmd        = sca_pkg::CMD_ALLOC;
      req_req_size   = '0;
      req_free_index = '0;
      cycle_count    = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part, back to back so the two-entry queue fills and busy rises.
      // Class boundaries at both ends, sizes beyond the last class, a free of a
      // held block, a double free, frees of blocks never issued and reuse of
      // freed blocks in last-in first-out order.
      send_request(sca_pkg::CMD_ALLOC, 16'd0,     6'd0);
      send_request(sca_pkg::CMD_ALLOC, 16'd4,     6'd63);
      send_request(sca_pkg::CMD_ALLOC, 16'd5,     6'd0);
      send_request(sca_pkg::CMD_ALLOC, 16'd8,     6'd0);
      send_request(sca_pkg::CMD_ALLOC, 16'd9,     6'd0);
      send_request(sca_pkg::CMD_ALLOC, 16'd512,   6'd0);
      send_request(sca_pkg::CMD_ALLOC, 16'd513,   6'd0);
      send_request(sca_pkg::CMD_ALLOC, 16'd65535, 6'd63);
      send_request(sca_pkg::CMD_FREE,  16'd65535, 6'd63);
      send_request(sca_pkg::CMD_FREE,  16'd512,   6'd0);
      send_request(sca_pkg::CMD_FREE,  16'd512,   6'd0);
      send_request(sca_pkg::CMD_FREE,  16'd300,   6'd63);
      send_request(sca_pkg::CMD_ALLOC, 16'd257,   6'd0);
      send_request(sca_pkg::CMD_FREE,  16'd3,     6'd1);
      send_request(sca_pkg::CMD_FREE,  16'd0,     6'd0);
      send_request(sca_pkg::CMD_ALLOC, 16'd1,     6'd0);
      send_request(sca_pkg::CMD_ALLOC, 16'd2,     6'd0);
      send_request(sca_pkg::CMD_ALLOC, 16'd3,     6'd0);
      send_request(sca_pkg::CMD_ALLOC, 16'd16,    6'd0);
      send_request(sca_pkg::CMD_ALLOC, 16'd17,    6'd0);
      send_request(sca_pkg::CMD_FREE,  16'd17,    6'd0);
      send_request(sca_pkg::CMD_ALLOC, 16'd256,   6'd63);
      send_request(sca_pkg::CMD_FREE,  16'd256,   6'd42);
      send_request(sca_pkg::CMD_ALLOC, 16'd32768, 6'd21);
      idle_for(pick_gap());

      // Random part: twelve stretches. The first three allocate heavily to run
      // classes dry; later ones mix allocation and release at random shares.
      // Every third stretch runs without gaps to keep the queue under pressure.
      for (int round = 0; round < 12; round++)
         random_round((round < 3) ? round * 3 : $urandom_range(0, sca_pkg::CLASSES - 1),
                      (round < 3) ? 92 : $urandom_range(25, 85),
                      (round % 3) == 2, 150);

      // Drain: wait for every result, then keep watching for stray strobes.
      start = 1'b0;
      while (outstanding != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);

      if (mismatch_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
